/* rtl/imgq_pkg.sv */
`default_nettype none

package imgq_pkg;

    // Field widths of the words on both channels
    localparam int MODE_W  = 3;
    localparam int EDGE_W  = 10;
    localparam int VTX_W   = 7;
    localparam int ANS_W   = 10;

    // Configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_EDGE_COUNT   = 1'b1;

    localparam logic [VTX_W-1:0]  VERTEX_COUNT_RESET = 7'd64;
    localparam logic [EDGE_W-1:0] EDGE_COUNT_RESET   = 10'd512;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADJ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEG   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NBR   = 3'd4;

    // Sequencer states
    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_ADD_RD = 7'b0000100,
        S_ADD_WR = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_RESULT = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

/* rtl/incidence_matrix_graph_query_core.sv */
// Channel   Direction  Handshake           Word
// input     in         i_valid / o_ready   i_mode, i_edge_index, i_vertex_x, i_vertex_y
// output    out        o_valid / i_ready   o_answer, o_has_answer, o_last_of_run
// config    in         psel/penable/pwrite paddr, pwdata, prdata, pready
//
// One word is taken at a time; o_ready stays low from acceptance until the sequencer is idle.
// Clear zeroes one column per cycle with o_ready low; add edge reads then writes a column.
// Adjacency and degree read one column per edge in use, fold the last read, then answer.
// Neighbour list scans alike, then walks vertices up to the top hit; if empty, one marker.
// After reset the same clearing pass runs with o_ready low.
// A stalled output only holds the sequencer when it has a new result to hand over.
`default_nettype none

module incidence_matrix_graph_query_core #(
    parameter int MAX_VERTICES   = 64,
    parameter int MAX_EDGE_SLOTS = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [imgq_pkg::MODE_W-1:0]  i_mode,
    input  logic [imgq_pkg::EDGE_W-1:0]  i_edge_index,
    input  logic [imgq_pkg::VTX_W-1:0]   i_vertex_x,
    input  logic [imgq_pkg::VTX_W-1:0]   i_vertex_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [imgq_pkg::ANS_W-1:0]   o_answer,
    output logic                         o_has_answer,
    output logic                         o_last_of_run,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [imgq_pkg::PADDR_W-1:0] paddr,
    input  logic [imgq_pkg::PDATA_W-1:0] pwdata,
    output logic [imgq_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import imgq_pkg::*;

    localparam int AW = (MAX_EDGE_SLOTS > 1) ? $clog2(MAX_EDGE_SLOTS) : 1;
    localparam int CW = $clog2(MAX_EDGE_SLOTS + 1);
    localparam int VW = $clog2(MAX_VERTICES);

    // Column memory: one vertex-bit column per edge slot
    logic [MAX_VERTICES-1:0] r_mem [MAX_EDGE_SLOTS];
    logic [MAX_VERTICES-1:0] r_rd_data;
    logic                    w_rd_en;
    logic [AW-1:0]           w_rd_addr;
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic [MAX_VERTICES-1:0] w_wr_data;

    // Control registers
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    logic [VTX_W-1:0]  r_vertex_count;
    logic [EDGE_W-1:0] r_edge_count;

    // Datapath registers
    logic [MODE_W-1:0]       r_mode, n_mode;
    logic [VW-1:0]           r_x_idx, n_x_idx;
    logic [VW-1:0]           r_y_idx, n_y_idx;
    logic                    r_x_ok, n_x_ok;
    logic                    r_y_ok, n_y_ok;
    logic [AW-1:0]           r_edge_addr, n_edge_addr;
    logic [MAX_VERTICES-1:0] r_add_bits, n_add_bits;
    logic [CW-1:0]           r_scan_addr, n_scan_addr;
    logic [MAX_VERTICES-1:0] r_reach, n_reach;
    logic [ANS_W-1:0]        r_deg, n_deg;
    logic [MAX_VERTICES-1:0] r_set, n_set;
    logic [VTX_W-1:0]        r_vtx, n_vtx;
    logic [ANS_W-1:0]        r_res_answer, n_res_answer;
    logic                    r_res_has, n_res_has;
    logic [ANS_W-1:0]        r_answer, n_answer;
    logic                    r_has, n_has;
    logic                    r_last, n_last;

    // Decode of the incoming word
    logic [VTX_W-1:0]        w_x_m1;
    logic [VTX_W-1:0]        w_y_m1;
    logic                    w_in_x_ok;
    logic                    w_in_y_ok;
    logic [31:0]             w_e_m1;
    logic                    w_in_e_ok;
    logic [MAX_VERTICES-1:0] w_in_bits;

    logic [CW-1:0]           w_ne;
    logic [VTX_W-1:0]        w_nv;
    logic [MAX_VERTICES-1:0] w_lim;
    logic [MAX_VERTICES-1:0] w_nbr_set;
    logic [MAX_VERTICES-1:0] w_rest;
    logic                    w_slot;
    logic                    w_hit;
    logic                    w_cfg_wr;

    assign w_x_m1    = i_vertex_x - 7'd1;
    assign w_y_m1    = i_vertex_y - 7'd1;
    assign w_in_x_ok = (i_vertex_x != '0) && (32'(i_vertex_x) <= 32'(MAX_VERTICES));
    assign w_in_y_ok = (i_vertex_y != '0) && (32'(i_vertex_y) <= 32'(MAX_VERTICES));
    assign w_e_m1    = 32'(i_edge_index) - 32'd1;
    assign w_in_e_ok = (i_edge_index != '0) && (32'(i_edge_index) <= 32'(MAX_EDGE_SLOTS));

    // Limit register values to the sizes built
    assign w_ne = (32'(r_edge_count) > 32'(MAX_EDGE_SLOTS)) ? CW'(MAX_EDGE_SLOTS)
                                                            : CW'(r_edge_count);
    assign w_nv = (32'(r_vertex_count) > 32'(MAX_VERTICES)) ? VTX_W'(MAX_VERTICES)
                                                            : r_vertex_count;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            w_lim[i]     = (32'(i) < 32'(w_nv));
            w_in_bits[i] = (w_in_x_ok && (32'(i) == 32'(w_x_m1)))
                        || (w_in_y_ok && (32'(i) == 32'(w_y_m1)));
        end
    end

    assign w_nbr_set = r_reach & w_lim;
    assign w_rest    = r_set >> 1;
    assign w_slot    = !r_out_valid || i_ready;
    assign w_hit     = r_pend && r_x_ok && r_rd_data[r_x_idx];
    assign w_cfg_wr  = psel && penable && pwrite;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_ready;
        n_mode       = r_mode;
        n_x_idx      = r_x_idx;
        n_y_idx      = r_y_idx;
        n_x_ok       = r_x_ok;
        n_y_ok       = r_y_ok;
        n_edge_addr  = r_edge_addr;
        n_add_bits   = r_add_bits;
        n_scan_addr  = r_scan_addr;
        n_reach      = r_reach;
        n_deg        = r_deg;
        n_set        = r_set;
        n_vtx        = r_vtx;
        n_res_answer = r_res_answer;
        n_res_has    = r_res_has;
        n_answer     = r_answer;
        n_has        = r_has;
        n_last       = r_last;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_edge_addr;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_edge_addr;
        w_wr_data    = r_rd_data | r_add_bits;

        case (r_state)
            S_CLEAR: begin
                // Sweep zero through every column
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_addr;
                w_wr_data  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MAX_EDGE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_mode      = i_mode;
                    n_x_idx     = w_x_m1[VW-1:0];
                    n_y_idx     = w_y_m1[VW-1:0];
                    n_x_ok      = w_in_x_ok;
                    n_y_ok      = w_in_y_ok;
                    n_edge_addr = w_e_m1[AW-1:0];
                    n_add_bits  = w_in_bits;
                    n_scan_addr = '0;
                    n_pend      = 1'b0;
                    n_reach     = '0;
                    n_deg       = '0;
                    case (i_mode)
                        MODE_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end
                        MODE_ADD: begin
                            if (w_in_e_ok) begin
                                n_state = S_ADD_RD;
                            end
                        end
                        MODE_ADJ, MODE_DEG, MODE_NBR: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_RD: begin
                w_rd_en = 1'b1;
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                // Merge the endpoint bits into the column read back
                w_wr_en = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                // Fold in the column that arrived this cycle
                if (w_hit) begin
                    n_reach = r_reach | r_rd_data;
                    if (r_deg != '1) begin
                        n_deg = r_deg + 1'b1;
                    end
                end
                if (r_scan_addr < w_ne) begin
                    w_rd_en     = 1'b1;
                    w_rd_addr   = r_scan_addr[AW-1:0];
                    n_scan_addr = r_scan_addr + 1'b1;
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_res_has = 1'b1;
                        case (r_mode)
                            MODE_ADJ: begin
                                n_res_answer = ANS_W'(r_x_ok && r_y_ok && r_reach[r_y_idx]);
                                n_state      = S_RESULT;
                            end
                            MODE_DEG: begin
                                n_res_answer = r_deg;
                                n_state      = S_RESULT;
                            end
                            MODE_NBR: begin
                                if (w_nbr_set == '0) begin
                                    n_res_answer = '0;
                                    n_res_has    = 1'b0;
                                    n_state      = S_RESULT;
                                end else begin
                                    n_set   = w_nbr_set;
                                    n_vtx   = 7'd1;
                                    n_state = S_EMIT;
                                end
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_RESULT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_answer    = r_res_answer;
                    n_has       = r_res_has;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_EMIT: begin
                // Walk the neighbour set, lowest vertex first
                if (r_set[0]) begin
                    if (w_slot) begin
                        n_out_valid = 1'b1;
                        n_answer    = ANS_W'(r_vtx);
                        n_has       = 1'b1;
                        n_last      = (w_rest == '0);
                        n_set       = w_rest;
                        n_vtx       = r_vtx + 1'b1;
                        if (w_rest == '0) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_set = w_rest;
                    n_vtx = r_vtx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_vertex_count <= VERTEX_COUNT_RESET;
            r_edge_count   <= EDGE_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                case (paddr[REG_SEL_BIT])
                    REG_VERTEX_COUNT: r_vertex_count <= pwdata[VTX_W-1:0];
                    REG_EDGE_COUNT:   r_edge_count   <= pwdata[EDGE_W-1:0];
                    default:          r_edge_count   <= r_edge_count;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_x_idx      <= n_x_idx;
        r_y_idx      <= n_y_idx;
        r_x_ok       <= n_x_ok;
        r_y_ok       <= n_y_ok;
        r_edge_addr  <= n_edge_addr;
        r_add_bits   <= n_add_bits;
        r_scan_addr  <= n_scan_addr;
        r_reach      <= n_reach;
        r_deg        <= n_deg;
        r_set        <= n_set;
        r_vtx        <= n_vtx;
        r_res_answer <= n_res_answer;
        r_res_has    <= n_res_has;
        r_answer     <= n_answer;
        r_has        <= n_has;
        r_last       <= n_last;
    end

    // Column memory ports
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Register read-back
    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_VERTEX_COUNT: prdata = PDATA_W'(r_vertex_count);
            REG_EDGE_COUNT:   prdata = PDATA_W'(r_edge_count);
            default:          prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_answer      = r_answer;
    assign o_has_answer  = r_has;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

/* rtl/imgq_checker.sv */
`default_nettype none

module imgq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [imgq_pkg::ANS_W-1:0]   o_answer,
    input logic                         o_has_answer,
    input logic                         o_last_of_run
);
    import imgq_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_answer)
            && $stable(o_has_answer) && $stable(o_last_of_run))
        else $error("result word changed while stalled");

    // An empty neighbour list ends its run and carries a zero answer
    a_empty_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_answer |-> o_last_of_run && (o_answer == '0))
        else $error("empty marker malformed");

    // Only neighbour lists run past one word, and they carry vertex numbers
    a_nbr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> o_has_answer && (o_answer != '0)
            && (o_answer <= ANS_W'(64)))
        else $error("neighbour word out of range");

    // The clearing pass keeps the input closed right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("input open during clearing pass");

endmodule

bind incidence_matrix_graph_query_core imgq_checker u_imgq_checker (.*);

`default_nettype wire
